// ===== rtl/core/stw_pkg.sv =====
// ----------------------------------------------------------------------------
// stw_pkg
// Shared types and codes for the short-descriptor table walker.
// ----------------------------------------------------------------------------
package stw_pkg;

  typedef enum logic {
    OP_TRANSLATE = 1'b0,
    OP_DATA      = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KIND_READ    = 2'd0,
    KIND_DONE    = 2'd1,
    KIND_FAULT   = 2'd2,
    KIND_IGNORED = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    SIZE_SUPER   = 2'd0,
    SIZE_SECTION = 2'd1,
    SIZE_LARGE   = 2'd2,
    SIZE_SMALL   = 2'd3
  } size_e;

  typedef enum logic [1:0] {
    CFG_TABLE0_BASE  = 2'd0,
    CFG_TABLE1_BASE  = 2'd1,
    CFG_TABLE_SPLIT  = 2'd2,
    CFG_CURRENT_ASID = 2'd3
  } cfg_idx_e;

  localparam int unsigned CfgIdxW = 2;

  typedef struct packed {
    op_e         opcode;
    logic [31:0] virt_addr;
    logic [31:0] read_data;
  } stw_in_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] read_addr;
    logic [31:0] phys_addr;
    size_e       page_size;
    logic [2:0]  access_bits;
    logic        no_exec;
    logic        non_global;
    logic [7:0]  asid_tag;
    logic        fault_level;
  } stw_out_t;

endpackage

// ===== rtl/core/short_descriptor_table_walker.sv =====
// ----------------------------------------------------------------------------
// short_descriptor_table_walker
// Throughput: one beat per cycle unless the output stalls; decode is a single
// mask-and-select stage whose result is registered into the output register,
// or into the skid register behind it while the output is stalled, so that
// the input keeps flowing for one more beat. Reset: walk returns to idle,
// configuration registers clear to zero, both output registers empty. Walks
// two-level short-descriptor translation tables.
// ----------------------------------------------------------------------------
module short_descriptor_table_walker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  stw_pkg::stw_in_t                 in_item_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output stw_pkg::stw_out_t                out_item_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [stw_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [31:0]                      cfg_data_i
);
  import stw_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_L1   = 2'd1,
    PH_L2   = 2'd2
  } walk_phase_e;

  walk_phase_e phase_q, phase_d;
  logic [31:0] saved_vaddr_q, saved_vaddr_d;
  logic [31:0] table0_base_q, table1_base_q;
  logic [2:0]  table_split_q;
  logic [7:0]  current_asid_q;

  logic        out_valid_q, skid_valid_q;
  stw_out_t    out_q, skid_q;
  stw_out_t    res;

  logic        accept;
  logic        out_fire;

  logic [13:0] l1_idx;
  logic [14:0] cutoff;
  logic [13:0] mask;
  logic [31:0] base_sel;
  logic [31:0] desc;
  logic [31:0] va;

  assign accept      = in_valid_i && !skid_valid_q;
  assign out_fire    = out_valid_q && !out_stall_i;
  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign cfg_ready_o = 1'b1;

  assign desc   = in_item_i.read_data;
  assign va     = saved_vaddr_q;
  assign l1_idx = {in_item_i.virt_addr[31:20], 2'b00};
  assign cutoff = 15'h4000 >> table_split_q;
  assign mask   = 14'h3FFF >> table_split_q;
  assign base_sel = ({1'b0, l1_idx} < cutoff) ? table0_base_q : table1_base_q;

  always_comb begin
    res           = '0;
    res.kind      = KIND_IGNORED;
    res.page_size = SIZE_SUPER;
    phase_d       = phase_q;
    saved_vaddr_d = saved_vaddr_q;
    if (in_item_i.opcode == OP_TRANSLATE) begin
      if (phase_q == PH_IDLE) begin
        saved_vaddr_d = in_item_i.virt_addr;
        res.kind      = KIND_READ;
        res.read_addr = (base_sel & ~{18'd0, mask}) + {18'd0, l1_idx};
        phase_d       = PH_L1;
      end
    end else begin
      case (phase_q)
        PH_L1: begin
          phase_d = PH_IDLE;
          case (desc[1:0])
            2'd2: begin
              res.kind        = KIND_DONE;
              res.access_bits = {desc[15], desc[11:10]};
              res.no_exec     = desc[4];
              res.non_global  = desc[17];
              res.asid_tag    = desc[17] ? current_asid_q : 8'd0;
              if (desc[18]) begin
                res.phys_addr = {desc[31:24], va[23:0]};
                res.page_size = SIZE_SUPER;
              end else begin
                res.phys_addr = {desc[31:20], va[19:0]};
                res.page_size = SIZE_SECTION;
              end
            end
            2'd1: begin
              res.kind      = KIND_READ;
              res.read_addr = {desc[31:10], va[19:12], 2'b00};
              phase_d       = PH_L2;
            end
            default: begin
              res.kind        = KIND_FAULT;
              res.fault_level = 1'b0;
            end
          endcase
        end
        PH_L2: begin
          phase_d = PH_IDLE;
          case (desc[1:0])
            2'd0: begin
              res.kind        = KIND_FAULT;
              res.fault_level = 1'b1;
            end
            2'd1: begin
              res.kind        = KIND_DONE;
              res.phys_addr   = {desc[31:16], va[15:0]};
              res.page_size   = SIZE_LARGE;
              res.access_bits = {desc[9], desc[5:4]};
              res.non_global  = desc[11];
              res.asid_tag    = desc[11] ? current_asid_q : 8'd0;
            end
            default: begin
              res.kind        = KIND_DONE;
              res.phys_addr   = {desc[31:12], va[11:0]};
              res.page_size   = SIZE_SMALL;
              res.access_bits = {desc[9], desc[5:4]};
              res.no_exec     = desc[0];
              res.non_global  = desc[11];
              res.asid_tag    = desc[11] ? current_asid_q : 8'd0;
            end
          endcase
        end
        default: begin
          res.kind = KIND_IGNORED;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_IDLE;
      table0_base_q  <= '0;
      table1_base_q  <= '0;
      table_split_q  <= '0;
      current_asid_q <= '0;
      out_valid_q    <= 1'b0;
      skid_valid_q   <= 1'b0;
    end else begin
      if (accept) begin
        phase_q <= phase_d;
      end
      if (cfg_valid_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_TABLE0_BASE:  table0_base_q  <= cfg_data_i;
          CFG_TABLE1_BASE:  table1_base_q  <= cfg_data_i;
          CFG_TABLE_SPLIT:  table_split_q  <= cfg_data_i[2:0];
          CFG_CURRENT_ASID: current_asid_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (!out_valid_q || out_fire) begin
        if (skid_valid_q) begin
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= accept;
        end
      end else if (accept) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      saved_vaddr_q <= saved_vaddr_d;
    end
    if (!out_valid_q || out_fire) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (accept) begin
      skid_q <= res;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register holds a beat while output register is empty");

  a_request_starts_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && phase_q == PH_IDLE && in_item_i.opcode == OP_TRANSLATE
      |=> phase_q == PH_L1)
    else $error("translate request did not start a first-level fetch");

  a_ignored_holds_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && res.kind == KIND_IGNORED |=> phase_q == $past(phase_q))
    else $error("ignored beat changed the walk phase");

  a_l2_ends_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && phase_q == PH_L2 && in_item_i.opcode == OP_DATA |=> phase_q == PH_IDLE)
    else $error("second-level descriptor did not end the walk");

  a_read_only_from_idle_or_l1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && res.kind == KIND_READ |-> phase_q == PH_IDLE || phase_q == PH_L1)
    else $error("descriptor read issued from second-level phase");

endmodule

// ===== verif/short_descriptor_table_walker_tb.sv =====
// ----------------------------------------------------------------------------
// short_descriptor_table_walker_tb
// Drives translate requests and descriptor words into the walker and checks
// every result beat against an in-bench two-level walk predictor. A directed
// burst covers faults, sections, supersections, coarse tables, large and small
// pages and out-of-phase beats. Random phases follow, under varied table
// settings, random idling on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module short_descriptor_table_walker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import stw_pkg::*;

  typedef enum logic [1:0] {
    WALK_IDLE = 2'd0,
    WALK_L1   = 2'd1,
    WALK_L2   = 2'd2
  } walk_state_e;

  localparam int QuietLimit = 2000;
  localparam int HoldCycles = 300;
  localparam int PhaseBeats = 100;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  stw_in_t             in_item_i;
  logic                out_valid_o;
  logic                out_stall_i;
  stw_out_t            out_item_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [31:0]         cfg_data_i;

  stw_in_t     queued_requests[$];
  stw_out_t    predicted_responses[$];
  stw_out_t    want;

  logic [31:0] tbl0_base;
  logic [31:0] tbl1_base;
  logic [2:0]  tbl_split;
  logic [7:0]  asid;
  walk_state_e walk_state;
  logic [31:0] walk_vaddr;

  int          send_idle_pct;
  int          recv_idle_pct;
  int          mismatches;
  int          quiet_cycles;
  int          stall_hold;
  logic        hold_req;
  logic        hold_taken;

  short_descriptor_table_walker uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic stw_out_t walk_predict(stw_in_t it);
    stw_out_t    r;
    logic [31:0] d;
    logic [31:0] idx;
    logic [31:0] mask;
    logic [31:0] cutoff;
    logic [31:0] base;
    logic [2:0]  ap;
    r = '0;
    d = it.read_data;
    if (it.opcode == OP_TRANSLATE) begin
      if (walk_state != WALK_IDLE) begin
        r.kind = KIND_IGNORED;
      end else begin
        idx    = {18'd0, it.virt_addr[31:20], 2'b00};
        mask   = 32'h3FFF >> tbl_split;
        cutoff = 32'h4000 >> tbl_split;
        base   = (idx < cutoff) ? tbl0_base : tbl1_base;
        walk_vaddr  = it.virt_addr;
        r.kind      = KIND_READ;
        r.read_addr = (base & ~mask) + idx;
        walk_state  = WALK_L1;
      end
    end else if (walk_state == WALK_L1) begin
      if (d[1:0] == 2'b00 || d[1:0] == 2'b11) begin
        r.kind        = KIND_FAULT;
        r.fault_level = 1'b0;
        walk_state    = WALK_IDLE;
      end else if (d[1:0] == 2'b10) begin
        ap            = {d[15], d[11:10]};
        r.kind        = KIND_DONE;
        r.access_bits = ap;
        r.no_exec     = d[4];
        r.non_global  = d[17];
        r.asid_tag    = d[17] ? asid : 8'd0;
        if (d[18]) begin
          r.phys_addr = {d[31:24], walk_vaddr[23:0]};
          r.page_size = SIZE_SUPER;
        end else begin
          r.phys_addr = {d[31:20], walk_vaddr[19:0]};
          r.page_size = SIZE_SECTION;
        end
        walk_state = WALK_IDLE;
      end else begin
        r.kind      = KIND_READ;
        r.read_addr = {d[31:10], walk_vaddr[19:12], 2'b00};
        walk_state  = WALK_L2;
      end
    end else if (walk_state == WALK_L2) begin
      ap = {d[9], d[5:4]};
      if (d[1:0] == 2'b00) begin
        r.kind        = KIND_FAULT;
        r.fault_level = 1'b1;
      end else begin
        r.kind        = KIND_DONE;
        r.access_bits = ap;
        r.non_global  = d[11];
        r.asid_tag    = d[11] ? asid : 8'd0;
        if (d[1:0] == 2'b01) begin
          r.phys_addr  = {d[31:16], walk_vaddr[15:0]};
          r.page_size  = SIZE_LARGE;
          r.no_exec    = 1'b0;
        end else begin
          r.phys_addr  = {d[31:12], walk_vaddr[11:0]};
          r.page_size  = SIZE_SMALL;
          r.no_exec    = d[0];
        end
      end
      walk_state = WALK_IDLE;
    end else begin
      r.kind = KIND_IGNORED;
    end
    return r;
  endfunction

  function automatic stw_in_t xlate(logic [31:0] va);
    stw_in_t it;
    it.opcode    = OP_TRANSLATE;
    it.virt_addr = va;
    it.read_data = $urandom;
    return it;
  endfunction

  function automatic stw_in_t desc(logic [31:0] d);
    stw_in_t it;
    it.opcode    = OP_DATA;
    it.virt_addr = $urandom;
    it.read_data = d;
    return it;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  task automatic cfg_write(cfg_idx_e idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_TABLE0_BASE:  tbl0_base = data;
      CFG_TABLE1_BASE:  tbl1_base = data;
      CFG_TABLE_SPLIT:  tbl_split = data[2:0];
      CFG_CURRENT_ASID: asid      = data[7:0];
      default: ;
    endcase
  endtask

  task automatic program_tables(logic [31:0] t0, logic [31:0] t1, logic [2:0] n,
                                logic [7:0] id);
    cfg_write(CFG_TABLE0_BASE, t0);
    cfg_write(CFG_TABLE1_BASE, t1);
    cfg_write(CFG_TABLE_SPLIT, {29'd0, n});
    cfg_write(CFG_CURRENT_ASID, {24'd0, id});
  endtask

  task automatic settle();
    while (queued_requests.size() != 0 || predicted_responses.size() != 0 || in_valid_i)
      @(negedge clk_i);
    // close any open walk with a fault so the next phase starts idle
    if (walk_state != WALK_IDLE) begin
      queued_requests.push_back(desc(32'h0));
      while (queued_requests.size() != 0 || predicted_responses.size() != 0 || in_valid_i)
        @(negedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic queue_random_walks(int n);
    int          made;
    int          pick;
    logic [31:0] va;
    logic [31:0] l1;
    logic [31:0] l2;
    stw_in_t     noise;
    made = 0;
    while (made < n) begin
      if ($urandom_range(9) == 0) begin
        noise.opcode    = op_e'($urandom_range(1));
        noise.virt_addr = $urandom;
        noise.read_data = $urandom;
        queued_requests.push_back(noise);
        made++;
      end else begin
        va = $urandom;
        if ($urandom_range(1) == 1)
          va = va >> $urandom_range(0, 8);
        queued_requests.push_back(xlate(va));
        pick = $urandom_range(99);
        l1   = $urandom;
        if (pick < 12)
          l1[1:0] = ($urandom_range(1) == 1) ? 2'b00 : 2'b11;
        else if (pick < 45)
          l1[1:0] = 2'b10;
        else
          l1[1:0] = 2'b01;
        queued_requests.push_back(desc(l1));
        made += 2;
        // drop the second-level word now and then to break the sequence
        if (l1[1:0] == 2'b01 && $urandom_range(19) != 0) begin
          l2 = $urandom;
          queued_requests.push_back(desc(l2));
          made++;
        end
      end
    end
  endtask

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o)
        predicted_responses.push_back(walk_predict(in_item_i));
      if (!in_valid_i || !in_stall_o) begin
        if (queued_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          in_item_i  <= queued_requests.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (predicted_responses.size() == 0) begin
          $error("result beat with nothing expected: kind 0x%0h", out_item_o.kind);
          mismatches++;
        end else begin
          want = predicted_responses.pop_front();
          check_field("kind", 32'(want.kind), 32'(out_item_o.kind));
          check_field("read_addr", want.read_addr, out_item_o.read_addr);
          check_field("phys_addr", want.phys_addr, out_item_o.phys_addr);
          check_field("page_size", 32'(want.page_size), 32'(out_item_o.page_size));
          check_field("access_bits", 32'(want.access_bits), 32'(out_item_o.access_bits));
          check_field("no_exec", 32'(want.no_exec), 32'(out_item_o.no_exec));
          check_field("non_global", 32'(want.non_global), 32'(out_item_o.non_global));
          check_field("asid_tag", 32'(want.asid_tag), 32'(out_item_o.asid_tag));
          check_field("fault_level", 32'(want.fault_level), 32'(out_item_o.fault_level));
        end
      end
      if (stall_hold != 0) begin
        out_stall_i <= 1'b1;
        stall_hold  <= stall_hold - 1;
      end else if (hold_req && !hold_taken) begin
        out_stall_i <= 1'b1;
        stall_hold  <= HoldCycles;
        hold_taken  <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("short_descriptor_table_walker: mismatch");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_item_i     = '0;
    out_stall_i   = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    tbl0_base     = '0;
    tbl1_base     = '0;
    tbl_split     = '0;
    asid          = '0;
    walk_state    = WALK_IDLE;
    walk_vaddr    = '0;
    mismatches    = 0;
    quiet_cycles  = 0;
    stall_hold    = 0;
    hold_req      = 1'b0;
    hold_taken    = 1'b0;
    send_idle_pct = 34;
    recv_idle_pct = 63;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    program_tables(32'h0000_3FFF, 32'hFFFF_FFFF, 3'd7, 8'hFF);
    queued_requests.push_back(desc(32'hFFFF_FFFF));
    queued_requests.push_back(xlate(32'h0000_0000));
    queued_requests.push_back(desc(32'h0000_0000));
    queued_requests.push_back(xlate(32'hFFFF_FFFF));
    queued_requests.push_back(desc(32'hFFFF_FFFF));
    queued_requests.push_back(xlate(32'h0123_4567));
    queued_requests.push_back(xlate(32'hFFFF_FFFF));
    queued_requests.push_back(desc(32'hFFFB_FFFE));
    queued_requests.push_back(xlate(32'hFEDC_BA98));
    queued_requests.push_back(desc(32'hFFFF_FFFE));
    queued_requests.push_back(xlate(32'h01FF_FFFF));
    queued_requests.push_back(desc(32'h0004_0002));
    queued_requests.push_back(xlate(32'h0200_0000));
    queued_requests.push_back(desc(32'hFFFF_FFFD));
    queued_requests.push_back(desc(32'hFFFF_FFFC));
    queued_requests.push_back(xlate(32'hFFFF_FFFF));
    queued_requests.push_back(desc(32'h0000_0001));
    queued_requests.push_back(xlate(32'h0000_0000));
    queued_requests.push_back(desc(32'hFFFF_FFFD));
    queued_requests.push_back(xlate(32'h0000_0000));
    queued_requests.push_back(desc(32'hFFFF_FFFD));
    queued_requests.push_back(desc(32'h0000_0002));
    queued_requests.push_back(xlate(32'h8000_0000));
    queued_requests.push_back(desc(32'h0000_0001));
    queued_requests.push_back(desc(32'hFFFF_FFFF));
    settle();

    for (int ph = 0; ph < 6; ph++) begin
      send_idle_pct = (ph < 2) ? 34 : (ph < 4) ? 63 : 0;
      recv_idle_pct = (ph < 2) ? 63 : (ph < 4) ? 34 : 0;
      if (ph == 0)
        program_tables(32'h0, 32'h0, 3'd0, 8'h00);
      else if (ph == 1)
        program_tables(32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7, 8'hFF);
      else
        program_tables($urandom, $urandom, 3'($urandom_range(7)), 8'($urandom));
      if (ph == 4)
        hold_req = 1'b1;
      queue_random_walks(PhaseBeats);
      settle();
    end

    if (mismatches == 0)
      $display("short_descriptor_table_walker: match");
    else
      $display("short_descriptor_table_walker: mismatch");
    $finish;
  end

endmodule
